/* sv/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg
// types, constants and the arctangent table shared by the quaternion to
// euler block
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int ACC_W   = 35;  // product sums, scale 2^28
   localparam int MUL_W   = 33;  // shared multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;
   localparam int CORD_W  = 36;  // cordic datapath width
   localparam int ANG_W   = 16;
   localparam int PITCH_W = 15;
   localparam int YAW_W   = 32;
   localparam int SQ_W    = 63;

   localparam logic signed [ACC_W-1:0]  HALF_Q28    = 35'sd134217728;
   localparam logic [ACC_W-1:0]         ONE_Q27     = 35'd134217728;
   localparam logic [30:0]              ONE_Q30     = 31'h40000000;
   localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CORD_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [CORD_W-1:0] NORM_HI     = 36'sd1073741824;
   localparam logic signed [CORD_W-1:0] NORM_LO     = 36'sd536870912;
   localparam logic signed [CORD_W-1:0] ROUND_HALF  = 36'sd65536;
   localparam logic [4:0]               ITER_LAST   = 5'd29;
   localparam logic signed [16:0]       YAW_JUMP    = 17'sd25736;
   localparam logic signed [MUL_W-1:0]  TURN_STEP   = 33'sd51471;

   // product order of the multiply phase
   localparam logic [3:0] P_YZ   = 4'd0;
   localparam logic [3:0] P_WX   = 4'd1;
   localparam logic [3:0] P_XX   = 4'd2;
   localparam logic [3:0] P_YY   = 4'd3;
   localparam logic [3:0] P_WY   = 4'd4;
   localparam logic [3:0] P_XZ   = 4'd5;
   localparam logic [3:0] P_XY   = 4'd6;
   localparam logic [3:0] P_WZ   = 4'd7;
   localparam logic [3:0] P_ZZ   = 4'd8;
   localparam logic [3:0] P_LAST = 4'd9;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROD, ST_ROLL, ST_ROLL_WAIT, ST_ASIN_PREP, ST_ASIN_MUL,
      ST_SQRT_INIT, ST_SQRT, ST_PITCH, ST_PITCH_WAIT, ST_YAW, ST_YAW_WAIT,
      ST_TURN, ST_OFFSET, ST_SUM, ST_RESP
   } q2e_state_type;

   typedef enum logic [2:0] {
      CS_IDLE, CS_NORM, CS_ITER, CS_FIN1, CS_FIN2
   } q2e_cord_state_type;

   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] num;
      logic signed [ACC_W-1:0] den;
   } q2e_cord_cmd_type;

   typedef struct packed {
      logic                    done;
      logic signed [ANG_W-1:0] angle;
   } q2e_cord_stat_type;

   function automatic logic signed [MUL_W-1:0] sx33(input logic signed [15:0] v);
      return MUL_W'(v);
   endfunction

   // atan(2^-i) in q30
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:    r = 30'd843314857;
         5'd1:    r = 30'd497837829;
         5'd2:    r = 30'd263043837;
         5'd3:    r = 30'd133525159;
         5'd4:    r = 30'd67021687;
         5'd5:    r = 30'd33543516;
         5'd6:    r = 30'd16775851;
         5'd7:    r = 30'd8388437;
         5'd8:    r = 30'd4194283;
         5'd9:    r = 30'd2097149;
         5'd10:   r = 30'd1048576;
         5'd11:   r = 30'd524288;
         5'd12:   r = 30'd262144;
         5'd13:   r = 30'd131072;
         5'd14:   r = 30'd65536;
         5'd15:   r = 30'd32768;
         5'd16:   r = 30'd16384;
         5'd17:   r = 30'd8192;
         5'd18:   r = 30'd4096;
         5'd19:   r = 30'd2048;
         5'd20:   r = 30'd1024;
         5'd21:   r = 30'd512;
         5'd22:   r = 30'd256;
         5'd23:   r = 30'd128;
         5'd24:   r = 30'd64;
         5'd25:   r = 30'd32;
         5'd26:   r = 30'd16;
         5'd27:   r = 30'd8;
         5'd28:   r = 30'd4;
         5'd29:   r = 30'd2;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

/* sv/q2e_if.sv */
// ----------------------------------------------------------------------------
// q2e channel interfaces
// valid / ready channels for quaternion beats and angle beats
// ----------------------------------------------------------------------------
interface q2e_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_rad;
   logic signed [14:0] pitch_rad;
   logic signed [31:0] yaw_unwrapped;

   modport source (output valid, roll_rad, pitch_rad, yaw_unwrapped, input ready);
   modport sink   (input valid, roll_rad, pitch_rad, yaw_unwrapped, output ready);
endinterface

/* sv/q2e_cordic.sv */
// ----------------------------------------------------------------------------
// q2e_cordic
// iterative atan2 unit: normalize, 30 vectoring steps, quadrant and rounding
// ----------------------------------------------------------------------------
module q2e_cordic import q2e_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  q2e_cord_cmd_type  cmd,
   output q2e_cord_stat_type stat
);

   q2e_cord_state_type cst_ff, cst_in;
   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, mag_ff, mag_in;
   logic [4:0]               it_ff, it_in;
   logic                     nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic signed [ANG_W-1:0]  ang_ff, ang_in;
   logic                     done_ff, done_in;

   logic signed [CORD_W-1:0] ux, uy, mx, dx, dy, at, zc, rsum;
   logic signed [ANG_W-1:0]  rnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cst_ff  <= CS_IDLE;
         done_ff <= 1'b0;
      end else begin
         cst_ff  <= cst_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      mag_ff  <= mag_in;
      it_ff   <= it_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      ang_ff  <= ang_in;
   end

   always_comb begin
      cst_in  = cst_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      mag_in  = mag_ff;
      it_in   = it_ff;
      nneg_in = nneg_ff;
      dneg_in = dneg_ff;
      ang_in  = ang_ff;
      done_in = 1'b0;
      ux   = cmd.den[ACC_W-1] ? -CORD_W'(cmd.den) : CORD_W'(cmd.den);
      uy   = cmd.num[ACC_W-1] ? -CORD_W'(cmd.num) : CORD_W'(cmd.num);
      mx   = (x_ff > y_ff) ? x_ff : y_ff;
      dx   = y_ff >>> it_ff;
      dy   = x_ff >>> it_ff;
      at   = CORD_W'(atan_q30(it_ff));
      zc   = z_ff[CORD_W-1] ? '0 : ((z_ff > HALF_PI_Q30) ? HALF_PI_Q30 : z_ff);
      rsum = mag_ff + ROUND_HALF;
      rnd  = rsum[32:17];
      case (cst_ff)
         CS_IDLE: begin
            if (cmd.start) begin
               x_in    = ux;
               y_in    = uy;
               z_in    = '0;
               it_in   = '0;
               nneg_in = cmd.num[ACC_W-1];
               dneg_in = cmd.den[ACC_W-1];
               if (ux == '0 && uy == '0) begin
                  ang_in  = '0;
                  done_in = 1'b1;
               end else begin
                  cst_in = CS_NORM;
               end
            end
         end
         CS_NORM: begin
            if (mx >= NORM_HI) begin
               x_in = x_ff >>> 1;
               y_in = y_ff >>> 1;
            end else if (mx < NORM_LO) begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end else begin
               cst_in = CS_ITER;
            end
         end
         CS_ITER: begin
            if (!y_ff[CORD_W-1]) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end
            it_in = it_ff + 5'd1;
            if (it_ff == ITER_LAST) cst_in = CS_FIN1;
         end
         CS_FIN1: begin
            mag_in = dneg_ff ? (PI_Q30 - zc) : zc;
            cst_in = CS_FIN2;
         end
         CS_FIN2: begin
            ang_in  = nneg_ff ? -rnd : rnd;
            done_in = 1'b1;
            cst_in  = CS_IDLE;
         end
         default: cst_in = CS_IDLE;
      endcase
   end

   assign stat.done  = done_ff;
   assign stat.angle = ang_ff;

endmodule

/* sv/quaternion_to_euler_unwrap_top.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_unwrap_top
// orientation quaternion to roll, pitch and turn-counted continuous yaw
// ----------------------------------------------------------------------------
// channel  dir  beat payload                               handshake
// req      in   quat_w, quat_x, quat_y, quat_z  (q1.14)    valid / ready
// rsp      out  roll_rad (q3.13), pitch_rad (q2.13), yaw_unwrapped valid / ready
//
// a beat runs from accept to result through the products, three atan2 passes
// through the cordic unit (normalize shifts are skipped when both operands are
// zero), asin setup (magnitude, product, root init), a 32-step square root,
// then the turn count, the turn offset and the yaw sum
// reset clears the sequencer, the previous wrapped yaw and the turn counter
// req.ready is high only while idle; a result beat holds until rsp.ready
// ----------------------------------------------------------------------------
module quaternion_to_euler_unwrap_top import q2e_pkg::*; #(
   parameter int TURN_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   q2e_req_if.sink     req,
   q2e_rsp_if.source   rsp
);

   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

   q2e_state_type state_ff, state_in;

   // captured quaternion
   logic signed [15:0] w_ff, w_in, x_ff, x_in, y_ff, y_in, z_ff, z_in;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [3:0]               pidx_ff, pidx_in, acc_sel;
   logic signed [ACC_W-1:0]  pval;

   // product sums: roll num/den, asin argument / 2, yaw num/den
   logic signed [ACC_W-1:0] rn_ff, rn_in, rd_ff, rd_in, tt_ff, tt_in;
   logic signed [ACC_W-1:0] yn_ff, yn_in, yd_ff, yd_in;

   // asin argument magnitude in q30, saturated to one
   logic [30:0]        m30_ff, m30_in, m30_c;
   logic [ACC_W-1:0]   tabs;

   // square root
   logic [SQ_W-1:0]    sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [SQ_W-1:0]    sq_sum;
   logic [4:0]         sq_cnt_ff, sq_cnt_in;

   // results and unwrap state
   logic signed [ANG_W-1:0]     roll_ff, roll_in, wrap_ff, wrap_in, last_ff, last_in;
   logic signed [PITCH_W-1:0]   pitch_ff, pitch_in;
   logic signed [YAW_W-1:0]     yaw_ff, yaw_in;
   logic signed [TURN_BITS-1:0] turn_ff, turn_in;
   logic signed [16:0]          ydiff, yabs;

   q2e_cord_cmd_type  cmd;
   q2e_cord_stat_type stat;

   q2e_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= '0;
         turn_ff  <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         turn_ff  <= turn_in;
      end
      w_ff      <= w_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      prod_ff   <= prod_in;
      pidx_ff   <= pidx_in;
      rn_ff     <= rn_in;
      rd_ff     <= rd_in;
      tt_ff     <= tt_in;
      yn_ff     <= yn_in;
      yd_ff     <= yd_in;
      m30_ff    <= m30_in;
      sq_v_ff   <= sq_v_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      sq_cnt_ff <= sq_cnt_in;
      roll_ff   <= roll_in;
      pitch_ff  <= pitch_in;
      wrap_ff   <= wrap_in;
      yaw_ff    <= yaw_in;
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PROD: begin
            case (pidx_ff)
               P_YZ:    begin mul_a = sx33(y_ff); mul_b = sx33(z_ff); end
               P_WX:    begin mul_a = sx33(w_ff); mul_b = sx33(x_ff); end
               P_XX:    begin mul_a = sx33(x_ff); mul_b = sx33(x_ff); end
               P_YY:    begin mul_a = sx33(y_ff); mul_b = sx33(y_ff); end
               P_WY:    begin mul_a = sx33(w_ff); mul_b = sx33(y_ff); end
               P_XZ:    begin mul_a = sx33(x_ff); mul_b = sx33(z_ff); end
               P_XY:    begin mul_a = sx33(x_ff); mul_b = sx33(y_ff); end
               P_WZ:    begin mul_a = sx33(w_ff); mul_b = sx33(z_ff); end
               P_ZZ:    begin mul_a = sx33(z_ff); mul_b = sx33(z_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_ASIN_MUL: begin
            // (1 - m)(1 + m) in q60
            mul_a = $signed({2'b00, ONE_Q30 - m30_ff});
            mul_b = $signed({1'b0, {1'b0, ONE_Q30} + {1'b0, m30_ff}});
         end
         ST_OFFSET: begin
            mul_a = TURN_STEP;
            mul_b = MUL_W'(turn_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      acc_sel = pidx_ff - 4'd1;  // product registered last cycle
      pval    = $signed(prod_ff[ACC_W-1:0]);
      tabs    = tt_ff[ACC_W-1] ? ACC_W'(-tt_ff) : ACC_W'(tt_ff);
      m30_c   = (tabs > ONE_Q27) ? ONE_Q30 : {tabs[27:0], 3'b000};
      sq_sum  = sq_res_ff + sq_bit_ff;
      ydiff   = 17'(wrap_ff) - 17'(last_ff);
      yabs    = ydiff[16] ? -ydiff : ydiff;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      w_in      = w_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      pidx_in   = pidx_ff;
      rn_in     = rn_ff;
      rd_in     = rd_ff;
      tt_in     = tt_ff;
      yn_in     = yn_ff;
      yd_in     = yd_ff;
      m30_in    = m30_ff;
      sq_v_in   = sq_v_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      sq_cnt_in = sq_cnt_ff;
      roll_in   = roll_ff;
      pitch_in  = pitch_ff;
      wrap_in   = wrap_ff;
      last_in   = last_ff;
      turn_in   = turn_ff;
      yaw_in    = yaw_ff;
      cmd.start = 1'b0;
      cmd.num   = rn_ff;
      cmd.den   = rd_ff;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               w_in     = req.quat_w;
               x_in     = req.quat_x;
               y_in     = req.quat_y;
               z_in     = req.quat_z;
               pidx_in  = P_YZ;
               rn_in    = '0;
               rd_in    = HALF_Q28;
               tt_in    = '0;
               yn_in    = '0;
               yd_in    = HALF_Q28;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            case (acc_sel)
               P_YZ:    rn_in = rn_ff + pval;
               P_WX:    rn_in = rn_ff + pval;
               P_XX:    rd_in = rd_ff - pval;
               P_YY:    begin rd_in = rd_ff - pval; yd_in = yd_ff - pval; end
               P_WY:    tt_in = tt_ff + pval;
               P_XZ:    tt_in = tt_ff - pval;
               P_XY:    yn_in = yn_ff + pval;
               P_WZ:    yn_in = yn_ff + pval;
               P_ZZ:    yd_in = yd_ff - pval;
               default: rn_in = rn_ff;
            endcase
            pidx_in = pidx_ff + 4'd1;
            if (pidx_ff == P_LAST) state_in = ST_ROLL;
         end
         ST_ROLL: begin
            cmd.start = 1'b1;
            state_in  = ST_ROLL_WAIT;
         end
         ST_ROLL_WAIT: begin
            if (stat.done) begin
               roll_in  = stat.angle;
               state_in = ST_ASIN_PREP;
            end
         end
         ST_ASIN_PREP: begin
            m30_in   = m30_c;
            state_in = ST_ASIN_MUL;
         end
         ST_ASIN_MUL: state_in = ST_SQRT_INIT;
         ST_SQRT_INIT: begin
            sq_v_in   = prod_ff[SQ_W-1:0];
            sq_res_in = '0;
            sq_bit_in = {1'b1, {(SQ_W-1){1'b0}}};
            sq_cnt_in = '1;
            state_in  = ST_SQRT;
         end
         ST_SQRT: begin
            // one result bit per cycle
            if (sq_v_ff >= sq_sum) begin
               sq_v_in   = sq_v_ff - sq_sum;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff - 5'd1;
            if (sq_cnt_ff == '0) state_in = ST_PITCH;
         end
         ST_PITCH: begin
            cmd.start = 1'b1;
            cmd.num   = $signed(ACC_W'(m30_ff));
            cmd.den   = $signed(sq_res_ff[ACC_W-1:0]);
            state_in  = ST_PITCH_WAIT;
         end
         ST_PITCH_WAIT: begin
            if (stat.done) begin
               pitch_in = tt_ff[ACC_W-1] ? -stat.angle[PITCH_W-1:0]
                                         : stat.angle[PITCH_W-1:0];
               state_in = ST_YAW;
            end
         end
         ST_YAW: begin
            cmd.start = 1'b1;
            cmd.num   = yn_ff;
            cmd.den   = yd_ff;
            state_in  = ST_YAW_WAIT;
         end
         ST_YAW_WAIT: begin
            if (stat.done) begin
               wrap_in  = stat.angle;
               state_in = ST_TURN;
            end
         end
         ST_TURN: begin
            // jump of more than pi: count a turn, saturating
            if (yabs > YAW_JUMP) begin
               if (!wrap_ff[ANG_W-1]) begin
                  if (turn_ff != TURN_MIN) turn_in = turn_ff - 1'b1;
               end else begin
                  if (turn_ff != TURN_MAX) turn_in = turn_ff + 1'b1;
               end
            end
            last_in  = wrap_ff;
            state_in = ST_OFFSET;
         end
         ST_OFFSET: state_in = ST_SUM;
         ST_SUM: begin
            yaw_in   = YAW_W'(wrap_ff) + $signed(prod_ff[YAW_W-1:0]);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp.valid = 1'b1;
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.roll_rad      = roll_ff;
   assign rsp.pitch_rad     = pitch_ff;
   assign rsp.yaw_unwrapped = yaw_ff;

endmodule

/* sv/q2e_chk.sv */
// ----------------------------------------------------------------------------
// q2e_chk
// port-level checks on the quaternion to euler block, bound to the top level
// ----------------------------------------------------------------------------
module q2e_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_roll_rad,
   input logic signed [14:0] rsp_pitch_rad
);

   // a result beat waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before taken");

   // one beat in flight at a time
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready while a result is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted beat");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_rad <= 16'sd25736 && rsp_roll_rad >= -16'sd25736))
      else $error("roll beyond pi");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_rad <= 15'sd12868 && rsp_pitch_rad >= -15'sd12868))
      else $error("pitch beyond pi/2");

endmodule

bind quaternion_to_euler_unwrap_top q2e_chk u_q2e_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_roll_rad  (rsp.roll_rad),
   .rsp_pitch_rad (rsp.pitch_rad)
);
